/* rtl/mbet_pkg.sv */
// Package for the Mandelbrot escape-time block.
// Holds the fixed field widths, the multiplier select codes and the
// command and status structs shared by the controller and the datapath.
package mbet_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned MAG_W  = 36;

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd256;

  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     update;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     check;
    logic     capture;
  } cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
      r = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/mbet_datapath.sv */
// Datapath of the Mandelbrot escape-time block: z and c registers, one
// shared 32x32 multiplier, the update adders, the escape test and the
// output register. Depends on mbet_pkg.
module mbet_datapath import mbet_pkg::*; #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_data_i,
  input  logic signed [DATA_W-1:0] c_real_i,
  input  logic signed [DATA_W-1:0] c_imag_i,
  output logic [CNT_W-1:0]         iteration_count_o,
  output logic                     inside_set_o,
  output logic signed [DATA_W-1:0] z_real_o,
  output logic signed [DATA_W-1:0] z_imag_o,
  output logic [MAG_W-1:0]         magnitude_squared_o
);

  localparam logic [PROD_W-1:0] FOUR = 64'd4 << FRAC_BITS;

  logic [CNT_W-1:0]         max_iter_q;
  logic [CNT_W-1:0]         limit_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_inc;
  logic signed [DATA_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [PROD_W-1:0] rr_q, ii_q, ri_q;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] re_wide, im_wide;
  logic [PROD_W-1:0]        sum, mag;
  logic [MAG_W-1:0]         mag_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_data_i;
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      MUL_II: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign re_wide = ((rr_q - ii_q) >>> FRAC_BITS) + PROD_W'(cr_q);
  assign im_wide = (ri_q >>> (FRAC_BITS - 1)) + PROD_W'(ci_q);

  assign sum       = rr_q + ii_q;
  assign mag       = sum >> FRAC_BITS;
  assign mag_sat   = (|mag[PROD_W-1:MAG_W]) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
  assign count_inc = count_q + 1'b1;

  assign sts_o.escape = (mag > FOUR);
  assign sts_o.last   = (count_inc == limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q    <= c_real_i;
      ci_q    <= c_imag_i;
      zr_q    <= '0;
      zi_q    <= '0;
      rr_q    <= '0;
      ii_q    <= '0;
      ri_q    <= '0;
      count_q <= '0;
      limit_q <= (max_iter_q == '0) ? CNT_W'(1) : max_iter_q;
    end else begin
      if (cmd_i.update) begin
        zr_q <= sat32(re_wide);
        zi_q <= sat32(im_wide);
      end
      if (cmd_i.mul_en) begin
        case (cmd_i.mul_sel)
          MUL_RR:  rr_q <= prod;
          MUL_II:  ii_q <= prod;
          default: ri_q <= prod;
        endcase
      end
      if (cmd_i.check && !sts_o.escape) begin
        count_q <= count_inc;
      end
    end
    if (cmd_i.capture) begin
      iteration_count_o   <= count_q;
      inside_set_o        <= !sts_o.escape;
      z_real_o            <= zr_q;
      z_imag_o            <= zi_q;
      magnitude_squared_o <= mag_sat;
    end
  end

endmodule

/* rtl/mbet_ctrl.sv */
// Controller of the Mandelbrot escape-time block: sequences load, update,
// the three multiplies and the escape check, and owns the output valid.
// Depends on mbet_pkg.
module mbet_ctrl import mbet_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_SQ_RE  = 3'd2;
  localparam logic [2:0] ST_SQ_IM  = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_capture;

  assign can_capture = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, update: 1'b0, mul_en: 1'b0, mul_sel: MUL_RR,
                check: 1'b0, capture: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RR;
        state_d       = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_II;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RI;
        cmd_o.check   = 1'b1;
        state_d       = (sts_i.escape || sts_i.last) ? ST_FINISH : ST_UPDATE;
      end
      ST_FINISH: begin
        if (can_capture) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_capture_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !(out_valid_q && out_stall_i))
    else $error("result captured over a stalled result");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("output valid raised outside finish");

  a_check_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |=> state_q == ST_UPDATE || state_q == ST_FINISH)
    else $error("bad exit from escape check");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_UPDATE)
    else $error("load did not start an iteration");

endmodule

/* rtl/mandelbrot_escape_time_top.sv */
// Top level of the Mandelbrot escape-time block.
// Instantiates mbet_ctrl and mbet_datapath; depends on mbet_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one point c in signed
//   Q4.28. A transaction is taken when in_valid_i is high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i) returns the iteration count,
//   inside flag, final z and final squared magnitude, one per point.
//   Config channel (cfg_valid_i / cfg_ready_o) writes max_iterations; a
//   value of 0 acts as 1. Write it only while the block is idle.
//   Timing: each iteration steps through the update, real-square, imag-square
//   and check states on the single shared 32x32 multiplier (three products
//   plus the z update). The next point is taken only after the current one
//   has been captured, as in_stall_o stays high outside the idle state.
//   A finished result waits in the output register while out_stall_i is high;
//   the next point may already be taken and iterated, and it holds in its
//   final state until the output register frees up.
//   Reset: rst_ni clears the controller and the output valid and sets
//   max_iterations to 256.
module mandelbrot_escape_time_top import mbet_pkg::*; #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] c_real_i,
  input  logic signed [DATA_W-1:0] c_imag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CNT_W-1:0]         iteration_count_o,
  output logic                     inside_set_o,
  output logic signed [DATA_W-1:0] z_real_o,
  output logic signed [DATA_W-1:0] z_imag_o,
  output logic [MAG_W-1:0]         magnitude_squared_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbet_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .c_real_i            (c_real_i),
    .c_imag_i            (c_imag_i),
    .iteration_count_o   (iteration_count_o),
    .inside_set_o        (inside_set_o),
    .z_real_o            (z_real_o),
    .z_imag_o            (z_imag_o),
    .magnitude_squared_o (magnitude_squared_o)
  );

endmodule

/* bench/mbet_escape_tb_pkg.sv */
`timescale 1ns / 1ps
// Escape-time predictor and result scoreboard for the Mandelbrot testbench.
// Depends on mbet_pkg for the field widths and the reset iteration limit.
package mbet_escape_tb_pkg;
  import mbet_pkg::*;

  localparam int unsigned Q_FRAC = 28;
  localparam longint unsigned ESCAPE_MAG = 64'd4 << Q_FRAC;
  localparam longint unsigned MAG_CAP = (64'd1 << MAG_W) - 64'd1;

  typedef struct packed {
    logic [CNT_W-1:0]         iterations;
    logic                     in_set;
    logic signed [DATA_W-1:0] zr;
    logic signed [DATA_W-1:0] zi;
    logic [MAG_W-1:0]         mag;
  } escape_result_t;

  function automatic longint clamp_q428(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      return longint'(32'sh7FFF_FFFF);
    end
    if (v < longint'(32'sh8000_0000)) begin
      return longint'(32'sh8000_0000);
    end
    return v;
  endfunction

  function automatic escape_result_t predict_escape(input logic signed [DATA_W-1:0] cr,
                                                    input logic signed [DATA_W-1:0] ci,
                                                    input logic [CNT_W-1:0] iter_limit);
    longint zr, zi, rr, ii, ri;
    longint unsigned sum, mag;
    int unsigned n, lim;
    bit escaped;
    escape_result_t res;
    zr = 0;
    zi = 0;
    mag = 0;
    n = 0;
    escaped = 1'b0;
    lim = (iter_limit == '0) ? 1 : int'(iter_limit);
    while (n < lim && !escaped) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      zr = clamp_q428(((rr - ii) >>> Q_FRAC) + longint'(cr));
      zi = clamp_q428((ri >>> (Q_FRAC - 1)) + longint'(ci));
      sum = longint'(zr * zr) + longint'(zi * zi);
      mag = sum >> Q_FRAC;
      if (mag > ESCAPE_MAG) begin
        escaped = 1'b1;
      end else begin
        n++;
      end
    end
    res.iterations = CNT_W'(n);
    res.in_set = !escaped;
    res.zr = zr[DATA_W-1:0];
    res.zi = zi[DATA_W-1:0];
    res.mag = (mag > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : mag[MAG_W-1:0];
    return res;
  endfunction

  class escape_scoreboard;
    logic [CNT_W-1:0] iter_limit;
    escape_result_t escape_results_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned in_set_count;
    int unsigned escaped_count;

    function new();
      iter_limit = MAX_ITER_RESET;
      mismatches = 0;
      checked = 0;
      in_set_count = 0;
      escaped_count = 0;
    endfunction

    function void set_limit(input logic [CNT_W-1:0] v);
      iter_limit = v;
    endfunction

    function void note_point(input logic signed [DATA_W-1:0] cr,
                             input logic signed [DATA_W-1:0] ci);
      escape_results_due.push_back(predict_escape(cr, ci, iter_limit));
    endfunction

    function void check_escape(input escape_result_t got);
      escape_result_t want;
      if (escape_results_due.size() == 0) begin
        $error("result with no point outstanding: iteration_count %0d", got.iterations);
        mismatches++;
        return;
      end
      want = escape_results_due.pop_front();
      checked++;
      if (want.in_set) begin
        in_set_count++;
      end else begin
        escaped_count++;
      end
      if (got.iterations !== want.iterations) begin
        $error("iteration_count: expected %0d, got %0d", want.iterations, got.iterations);
        mismatches++;
      end
      if (got.in_set !== want.in_set) begin
        $error("inside_set: expected %0d, got %0d", want.in_set, got.in_set);
        mismatches++;
      end
      if (got.zr !== want.zr) begin
        $error("z_real: expected %0d, got %0d", want.zr, got.zr);
        mismatches++;
      end
      if (got.zi !== want.zi) begin
        $error("z_imag: expected %0d, got %0d", want.zi, got.zi);
        mismatches++;
      end
      if (got.mag !== want.mag) begin
        $error("magnitude_squared: expected %0d, got %0d", want.mag, got.mag);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* bench/mandelbrot_escape_time_top_tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for mandelbrot_escape_time_top: directed and random points
// under several iteration limits, checked against mbet_escape_tb_pkg's scoreboard.
// Depends on mbet_pkg, mbet_escape_tb_pkg and the block's RTL.
module mandelbrot_escape_time_top_tb;
  import mbet_pkg::*;
  import mbet_escape_tb_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 6_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int Q_ONE = 1 << Q_FRAC;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CNT_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] c_real_i;
  logic signed [DATA_W-1:0] c_imag_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [CNT_W-1:0]         iteration_count_o;
  logic                     inside_set_o;
  logic signed [DATA_W-1:0] z_real_o;
  logic signed [DATA_W-1:0] z_imag_o;
  logic [MAG_W-1:0]         magnitude_squared_o;

  escape_scoreboard sb;
  bit               calm;
  int unsigned      cycle_cnt = 0;
  int unsigned      points_sent = 0;
  int unsigned      settings_run = 0;

  mandelbrot_escape_time_top #(
    .FRAC_BITS(Q_FRAC)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .c_real_i           (c_real_i),
    .c_imag_i           (c_imag_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .iteration_count_o  (iteration_count_o),
    .inside_set_o       (inside_set_o),
    .z_real_o           (z_real_o),
    .z_imag_o           (z_imag_o),
    .magnitude_squared_o(magnitude_squared_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_escape({iteration_count_o, inside_set_o, z_real_o, z_imag_o,
                       magnitude_squared_o});
    end
  end

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = pick_idle();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  task automatic send_point(input logic signed [DATA_W-1:0] cr,
                            input logic signed [DATA_W-1:0] ci);
    int unsigned gap;
    gap = pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    c_real_i <= cr;
    c_imag_i <= ci;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(cr, ci);
    points_sent++;
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    while (sb.escape_results_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
    settings_run++;
  endtask

  // Mostly points around the set, where runs get long; some raw 32-bit noise.
  task automatic draw_point(output logic signed [DATA_W-1:0] cr,
                            output logic signed [DATA_W-1:0] ci);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      cr = $urandom;
      ci = $urandom;
    end else if (mode < 8) begin
      cr = -(2 * Q_ONE) + int'($urandom_range(0, 2 * Q_ONE + Q_ONE / 2));
      ci = int'($urandom_range(0, 5 * Q_ONE / 2)) - 5 * Q_ONE / 4;
    end else begin
      cr = -(2 * Q_ONE) + int'($urandom_range(0, 9 * (Q_ONE / 4)));
      ci = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] lim, input int unsigned count);
    logic signed [DATA_W-1:0] cr, ci;
    write_limit(lim);
    calm = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      draw_point(cr, ci);
      send_point(cr, ci);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    c_real_i <= '0;
    c_imag_i <= '0;
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit of 256
    send_point(0, 0);
    send_point(-(2 * Q_ONE), 0);
    send_point(2 * Q_ONE, 0);
    send_point(2 * Q_ONE + 1, 0);
    send_point(0, 2 * Q_ONE);
    send_point(0, -(2 * Q_ONE));
    send_point(Q_ONE / 4, 0);
    send_point(Q_ONE / 4 + Q_ONE / 64, 0);
    send_point(-Q_ONE, 0);
    send_point(0, Q_ONE);
    send_point(-(3 * Q_ONE / 4), Q_ONE / 10);
    send_point(Q_ONE, 0);
    send_point(-(2 * Q_ONE), -(2 * Q_ONE));
    send_point(-(2 * Q_ONE), 1);
    send_point(Q_MIN, Q_MIN);
    send_point(Q_MAX, Q_MAX);
    send_point(Q_MIN, Q_MAX);
    send_point(Q_MAX, Q_MIN);
    send_point(1, -1);
    send_point(-1, 1);
    in_valid_i <= 1'b0;

    run_phase(16'd1, 50);
    run_phase(16'd0, 40);
    run_phase(16'd2, 40);
    run_phase(16'd13, 50);
    run_phase(16'd64, 50);
    run_phase(16'd1000, 40);
    run_phase(CNT_W'($urandom_range(3, 400)), 50);
    run_phase(CNT_W'($urandom_range(3, 400)), 50);

    // full 16-bit limit: one point that never leaves, one slow escape near the cusp, one quick escape
    write_limit(16'hFFFF);
    calm = 1'b0;
    send_point(0, 0);
    send_point(Q_ONE / 4 + (1 << 8), 0);
    send_point(3 * Q_ONE, -Q_ONE);
    in_valid_i <= 1'b0;

    run_phase(MAX_ITER_RESET, 50);

    while (sb.escape_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d points under %0d iteration limits, 0 through 65535, in %0d cycles",
             points_sent, settings_run + 1, cycle_cnt);
    $display("Results checked: %0d (%0d stayed in the set, %0d escaped), mismatches: %0d",
             sb.checked, sb.in_set_count, sb.escaped_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.escape_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* mandelbrot_escape_time_top.f */
rtl/mbet_pkg.sv
rtl/mbet_datapath.sv
rtl/mbet_ctrl.sv
rtl/mandelbrot_escape_time_top.sv
bench/mbet_escape_tb_pkg.sv
bench/mandelbrot_escape_time_top_tb.sv
